// ===== design/pps_pkg.sv =====
// Shared types and constants of the phase parking servo.
package pps_pkg;

  localparam int PHASE_W   = 16;
  localparam int COUNT_W   = 22;
  localparam int ITER_W    = 8;
  localparam int GAIN_W    = 32;
  localparam int GAIN_FRAC = 22;
  localparam int ACTION_W  = 2;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd4;

  localparam logic [PHASE_W-1:0] PERIOD_RESET = 16'd1120;
  localparam logic [ITER_W-1:0]  LIMIT_RESET  = 8'd64;
  localparam logic [GAIN_W-1:0]  GAIN_DEFAULT =
    GAIN_W'(((64'd1 << GAIN_FRAC) + 64'd5) / 64'd10);
  localparam logic [PHASE_W-1:0] MOVE_DEN = 16'd10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PULSE  = 2'd0,
    ACT_PARKED = 2'd1,
    ACT_LIMIT  = 2'd2,
    ACT_FAILED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_LAST,
    ST_MOD_PHASE,
    ST_LEARN,
    ST_RATIO,
    ST_PLAN,
    ST_MOD_TGT,
    ST_GAP,
    ST_MOVE,
    ST_PULSE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               start_req;
    logic               failed;
  } in_item_t;

  typedef struct packed {
    action_t            action;
    logic [COUNT_W-1:0] pulse_count;
    logic [PHASE_W-1:0] final_phase;
    logic [ITER_W-1:0]  iterations;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== design/phase_park_servo.sv =====
// Closed-loop phase parking servo: top level with sequencer and run state.
//
// One measurement item enters on in_valid/in_ready and one result item leaves
// on out_valid/out_ready for each. A result either asks for a pulse of
// pulse_count substeps or ends the run (parked, iteration limit, failed).
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata with
// no wait; write them only while no item is in flight.
// All divisions and period reductions go through one bit-serial divider that
// retires one quotient bit per cycle, so latency is set by the dividend bits
// each item needs; a measurement that moved the phase adds a division for the
// gain update. One item is worked at a time; in_ready is high only while the
// sequencer is idle, from the cycle after the result is loaded. The finished
// result sits in an output register, so the next item is taken while a result
// still waits; a stalled receiver holds the sequencer only when a second
// result is ready to be loaded.
// Synchronous reset clears the run state, the gain to 0.1 and the registers
// to their reset values, and empties the output register.
module phase_park_servo #(
  parameter int unsigned PROBE_PULSES = 200,
  parameter int unsigned PULSE_LIMIT  = 4000000
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pps_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pps_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [pps_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int PW = pps_pkg::PHASE_W;
  localparam int NCW = pps_pkg::COUNT_W;
  localparam int IW = pps_pkg::ITER_W;
  localparam int GW = pps_pkg::GAIN_W;
  localparam int NW = pps_pkg::DIV_NUM_W;
  localparam int DW = pps_pkg::DIV_DEN_W;
  localparam int BW = pps_pkg::DIV_CNT_W;
  localparam int G7W = PW + 3;

  localparam logic [NCW-1:0] PROBE_N   = NCW'(PROBE_PULSES);
  localparam logic [NW-1:0]  LIMIT_W   = NW'(PULSE_LIMIT);
  localparam logic [NCW-1:0] LIMIT_N   = NCW'(PULSE_LIMIT);
  localparam logic [BW-1:0]  MOD_BITS  = BW'(PW);
  localparam logic [BW-1:0]  QUO_BITS  = BW'(PW + pps_pkg::GAIN_FRAC);
  localparam logic [BW-1:0]  MOVE_BITS = BW'(G7W);

  pps_pkg::state_t    state, state_next;
  logic               launch, launch_next;
  logic               run_active, run_active_next;
  logic               learn_en, learn_en_next;
  pps_pkg::dir_t      dir, dir_next;
  logic [GW-1:0]      gain, gain_next;
  logic [IW-1:0]      tally, tally_next;
  logic [NCW-1:0]     last_pulse, last_pulse_next;
  logic [PW-1:0]      last_phase, last_phase_next;

  logic [PW-1:0]      ph, ph_next;
  logic [PW-1:0]      q0, q0_next;
  logic [PW-1:0]      q1, q1_next;
  logic [PW-1:0]      tq, tq_next;
  logic [PW-1:0]      ad, ad_next;
  logic [G7W-1:0]     g7, g7_next;
  logic [PW-1:0]      move, move_next;
  pps_pkg::out_item_t res, res_next;
  logic               out_load;

  logic [PW-1:0]      target_phase;
  logic [PW-1:0]      tolerance;
  logic [PW-1:0]      wrap_period;
  logic [IW-1:0]      iteration_limit;
  logic [GW-1:0]      initial_gain;

  pps_pkg::div_cmd_t  div_cmd;
  pps_pkg::div_rsp_t  div_rsp;

  logic [PW-1:0]      period;
  logic [PW:0]        fwd_wide;
  logic [PW-1:0]      fwd;
  logic               fwd_pos;
  logic [PW-1:0]      ad_calc;
  logic [PW:0]        gap_wide;
  logic [PW-1:0]      gap;
  logic               in_tol;
  logic [NW:0]        gain_sum;
  logic [NW-1:0]      gain_half;
  logic [GW-1:0]      gain_new;
  logic [NCW-1:0]     pulse_n;
  logic [NCW-1:0]     pulse_len;

  pps_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  assign period = (wrap_period == '0) ? PW'(1) : wrap_period;

  assign fwd_wide = (q1 >= q0) ? {1'b0, q1} - {1'b0, q0}
                               : {1'b0, q1} + {1'b0, period} - {1'b0, q0};
  assign fwd      = fwd_wide[PW-1:0];
  assign fwd_pos  = fwd <= (period >> 1);
  assign ad_calc  = fwd_pos ? fwd : period - fwd;

  always_comb begin
    if (dir == pps_pkg::DIR_UP) begin
      gap_wide = (tq >= q1) ? {1'b0, tq} - {1'b0, q1}
                            : {1'b0, tq} + {1'b0, period} - {1'b0, q1};
    end else begin
      gap_wide = (q1 >= tq) ? {1'b0, q1} - {1'b0, tq}
                            : {1'b0, q1} + {1'b0, period} - {1'b0, tq};
    end
  end

  assign gap    = gap_wide[PW-1:0];
  assign in_tol = (gap <= tolerance) || (tolerance >= period) ||
                  (gap >= period - tolerance);

  assign gain_sum  = {{(NW + 1 - GW){1'b0}}, gain} + {1'b0, div_rsp.quo};
  assign gain_half = gain_sum[NW:1];
  assign gain_new  = (|gain_half[NW-1:GW]) ? '1 :
                     (gain_half[GW-1:0] == '0) ? GW'(1) : gain_half[GW-1:0];

  assign pulse_len = (last_pulse == '0) ? NCW'(1) : last_pulse;
  assign pulse_n   = (div_rsp.quo == '0) ? NCW'(1) :
                     (div_rsp.quo > LIMIT_W) ? LIMIT_N : div_rsp.quo[NCW-1:0];

  assign out_load = (state == pps_pkg::ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next      = state;
    launch_next     = 1'b0;
    run_active_next = run_active;
    learn_en_next   = learn_en;
    dir_next        = dir;
    gain_next       = gain;
    tally_next      = tally;
    last_pulse_next = last_pulse;
    last_phase_next = last_phase;
    ph_next         = ph;
    q0_next         = q0;
    q1_next         = q1;
    tq_next         = tq;
    ad_next         = ad;
    g7_next         = g7;
    move_next       = move;
    res_next        = res;
    in_ready        = 1'b0;
    div_cmd         = '0;
    div_cmd.start   = launch;
    case (state)
      pps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ph_next = in_data.phase;
          if (in_data.start_req || !run_active) begin
            dir_next        = pps_pkg::DIR_NONE;
            tally_next      = '0;
            last_pulse_next = '0;
            gain_next       = (initial_gain != '0) ? initial_gain : pps_pkg::GAIN_DEFAULT;
            if (in_data.failed) begin
              run_active_next      = 1'b0;
              res_next.action      = pps_pkg::ACT_FAILED;
              res_next.pulse_count = '0;
              res_next.final_phase = '0;
              res_next.iterations  = '0;
              state_next           = pps_pkg::ST_OUT;
            end else begin
              run_active_next = 1'b1;
              last_phase_next = in_data.phase;
              learn_en_next   = 1'b0;
              launch_next     = 1'b1;
              state_next      = pps_pkg::ST_MOD_PHASE;
            end
          end else if (in_data.failed) begin
            run_active_next      = 1'b0;
            res_next.action      = pps_pkg::ACT_FAILED;
            res_next.pulse_count = '0;
            res_next.final_phase = '0;
            res_next.iterations  = tally;
            state_next           = pps_pkg::ST_OUT;
          end else begin
            learn_en_next = 1'b1;
            launch_next   = 1'b1;
            state_next    = pps_pkg::ST_MOD_LAST;
          end
        end
      end
      pps_pkg::ST_MOD_LAST: begin
        div_cmd.num   = {last_phase, {(NW - PW){1'b0}}};
        div_cmd.den   = DW'(period);
        div_cmd.nbits = MOD_BITS;
        if (div_rsp.done) begin
          q0_next     = div_rsp.rem[PW-1:0];
          launch_next = 1'b1;
          state_next  = pps_pkg::ST_MOD_PHASE;
        end
      end
      pps_pkg::ST_MOD_PHASE: begin
        div_cmd.num   = {ph, {(NW - PW){1'b0}}};
        div_cmd.den   = DW'(period);
        div_cmd.nbits = MOD_BITS;
        if (div_rsp.done) begin
          q1_next         = div_rsp.rem[PW-1:0];
          last_phase_next = ph;
          state_next      = learn_en ? pps_pkg::ST_LEARN : pps_pkg::ST_PLAN;
        end
      end
      pps_pkg::ST_LEARN: begin
        if (fwd == '0) begin
          state_next = pps_pkg::ST_PLAN;
        end else begin
          ad_next = ad_calc;
          if (dir == pps_pkg::DIR_NONE) begin
            dir_next = fwd_pos ? pps_pkg::DIR_UP : pps_pkg::DIR_DOWN;
          end
          launch_next = 1'b1;
          state_next  = pps_pkg::ST_RATIO;
        end
      end
      pps_pkg::ST_RATIO: begin
        div_cmd.num   = {ad, {(NW - PW){1'b0}}};
        div_cmd.den   = DW'(pulse_len);
        div_cmd.nbits = QUO_BITS;
        if (div_rsp.done) begin
          gain_next  = gain_new;
          state_next = pps_pkg::ST_PLAN;
        end
      end
      pps_pkg::ST_PLAN: begin
        if (tally >= iteration_limit) begin
          run_active_next      = 1'b0;
          res_next.action      = pps_pkg::ACT_LIMIT;
          res_next.pulse_count = '0;
          res_next.final_phase = last_phase;
          res_next.iterations  = tally;
          state_next           = pps_pkg::ST_OUT;
        end else if (dir == pps_pkg::DIR_NONE) begin
          last_pulse_next      = PROBE_N;
          tally_next           = tally + IW'(1);
          res_next.action      = pps_pkg::ACT_PULSE;
          res_next.pulse_count = PROBE_N;
          res_next.final_phase = last_phase;
          res_next.iterations  = tally + IW'(1);
          state_next           = pps_pkg::ST_OUT;
        end else begin
          launch_next = 1'b1;
          state_next  = pps_pkg::ST_MOD_TGT;
        end
      end
      pps_pkg::ST_MOD_TGT: begin
        div_cmd.num   = {target_phase, {(NW - PW){1'b0}}};
        div_cmd.den   = DW'(period);
        div_cmd.nbits = MOD_BITS;
        if (div_rsp.done) begin
          tq_next    = div_rsp.rem[PW-1:0];
          state_next = pps_pkg::ST_GAP;
        end
      end
      pps_pkg::ST_GAP: begin
        if (in_tol) begin
          run_active_next      = 1'b0;
          res_next.action      = pps_pkg::ACT_PARKED;
          res_next.pulse_count = '0;
          res_next.final_phase = last_phase;
          res_next.iterations  = tally;
          state_next           = pps_pkg::ST_OUT;
        end else begin
          g7_next     = {gap, 3'b000} - {3'b000, gap};
          launch_next = 1'b1;
          state_next  = pps_pkg::ST_MOVE;
        end
      end
      pps_pkg::ST_MOVE: begin
        div_cmd.num   = {g7, {(NW - G7W){1'b0}}};
        div_cmd.den   = DW'(pps_pkg::MOVE_DEN);
        div_cmd.nbits = MOVE_BITS;
        if (div_rsp.done) begin
          move_next   = div_rsp.quo[PW-1:0];
          launch_next = 1'b1;
          state_next  = pps_pkg::ST_PULSE;
        end
      end
      pps_pkg::ST_PULSE: begin
        div_cmd.num   = {move, {(NW - PW){1'b0}}};
        div_cmd.den   = gain;
        div_cmd.nbits = QUO_BITS;
        if (div_rsp.done) begin
          last_pulse_next      = pulse_n;
          tally_next           = tally + IW'(1);
          res_next.action      = pps_pkg::ACT_PULSE;
          res_next.pulse_count = pulse_n;
          res_next.final_phase = last_phase;
          res_next.iterations  = tally + IW'(1);
          state_next           = pps_pkg::ST_OUT;
        end
      end
      pps_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pps_pkg::ST_IDLE;
      launch     <= 1'b0;
      run_active <= 1'b0;
      learn_en   <= 1'b0;
      dir        <= pps_pkg::DIR_NONE;
      gain       <= pps_pkg::GAIN_DEFAULT;
      tally      <= '0;
      last_pulse <= '0;
      last_phase <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      launch     <= launch_next;
      run_active <= run_active_next;
      learn_en   <= learn_en_next;
      dir        <= dir_next;
      gain       <= gain_next;
      tally      <= tally_next;
      last_pulse <= last_pulse_next;
      last_phase <= last_phase_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ph   <= ph_next;
    q0   <= q0_next;
    q1   <= q1_next;
    tq   <= tq_next;
    ad   <= ad_next;
    g7   <= g7_next;
    move <= move_next;
    res  <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_phase    <= '0;
      tolerance       <= '0;
      wrap_period     <= pps_pkg::PERIOD_RESET;
      iteration_limit <= pps_pkg::LIMIT_RESET;
      initial_gain    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        pps_pkg::CFG_TARGET: target_phase    <= cfg_wdata[PW-1:0];
        pps_pkg::CFG_TOL:    tolerance       <= cfg_wdata[PW-1:0];
        pps_pkg::CFG_PERIOD: wrap_period     <= cfg_wdata[PW-1:0];
        pps_pkg::CFG_LIMIT:  iteration_limit <= cfg_wdata[IW-1:0];
        pps_pkg::CFG_GAIN:   initial_gain    <= cfg_wdata[GW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/pps_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, dividend left-justified.
module pps_div (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::div_cmd_t  cmd,
  output pps_pkg::div_rsp_t  rsp
);

  localparam int NW = pps_pkg::DIV_NUM_W;
  localparam int DW = pps_pkg::DIV_DEN_W;
  localparam int CW = pps_pkg::DIV_CNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num_sh;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem, num_sh[NW-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.nbits;
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num_sh <= cmd.num;
      den    <= cmd.den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NW-2:0], 1'b0};
      rem    <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo    <= {quo[NW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// ===== design/pps_checker.sv =====
// Port-level checks of the phase parking servo, bound to its top level.
module pps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input pps_pkg::out_item_t              out_data,
  input logic                            cfg_we
);

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before the first was answered");

  a_count_only_on_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action != pps_pkg::ACT_PULSE) |-> out_data.pulse_count == '0)
    else $error("pulse count on a run-ending item");

  a_pulse_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action == pps_pkg::ACT_PULSE) |->
      (out_data.pulse_count != '0) && (out_data.iterations != '0))
    else $error("pulse item with zero count or zero iterations");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item dropped or changed while stalled");

  a_cfg_quiet: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> in_ready && !out_valid)
    else $error("register written while an item is in flight");

endmodule

bind phase_park_servo pps_checker u_pps_checker (.*);
